// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker module brb_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/brb_pkg.sv -----
// shared constants for the byte ring buffer
// no dependencies
package brb_pkg;

  localparam int DATA_W     = 64;
  localparam int CFG_W      = 11;
  localparam int COUNT_W    = 4;
  localparam int LEVEL_W    = 11;
  localparam int RING_DEPTH_DEF        = 1024;
  localparam int BYTES_PER_REQUEST_DEF = 8;
  localparam int CAP_RESET  = 1024;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

endpackage

// ----- rtl/core/brb_ram.sv -----
// generic single-port synchronous ram with registered read data
// no dependencies
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/byte_ring_buffer_transfers.sv -----
// top level of the byte ring buffer: request sequencer around the byte ram
// depends on brb_pkg and brb_ram
//
// Usage:
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes the capacity;
//   a write empties the ring. Taken only while no request is in flight.
//   Request channel (in_valid_i / in_stall_o) takes a write or read of
//   byte_count bytes, all or nothing. Result channel (out_valid_o /
//   out_stall_i) gives one result per request with fill level and free space.
//   Bytes move through a single-port byte ram, one byte per cycle. A write
//   goes through the write state, a read through the read state and then a
//   drain state for the ram read latency; both then pass the finish state,
//   which loads the result register. Refused and empty requests go straight
//   to the finish state. The request channel stalls until the state is idle.
//   The result sits in an output register, so the next request is taken
//   while a result waits; if the receiver stalls, the following result
//   holds the sequencer until the register frees up.
//   Reset empties the ring and sets capacity to its default; ram contents
//   are not cleared.
module byte_ring_buffer_transfers import brb_pkg::*; #(
  parameter int RING_DEPTH        = RING_DEPTH_DEF,
  parameter int BYTES_PER_REQUEST = BYTES_PER_REQUEST_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_W-1:0]   cfg_capacity_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [COUNT_W-1:0] byte_count_i,
  input  logic [DATA_W-1:0]  write_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               accepted_o,
  output logic [COUNT_W-1:0] shortfall_o,
  output logic [DATA_W-1:0]  read_data_o,
  output logic [LEVEL_W-1:0] fill_level_o,
  output logic [LEVEL_W-1:0] free_space_o
);

  localparam int AW       = $clog2(RING_DEPTH);
  localparam int CNT_W    = $clog2(RING_DEPTH + 1);
  localparam int LANE_W   = (BYTES_PER_REQUEST > 1) ? $clog2(BYTES_PER_REQUEST) : 1;
  localparam int CapReset = (CAP_RESET > RING_DEPTH) ? RING_DEPTH : CAP_RESET;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [CNT_W-1:0]    cap_q;
  logic [CNT_W-1:0]    stored_q;
  logic [AW-1:0]       wr_pos_q;
  logic [AW-1:0]       rd_pos_q;
  logic [COUNT_W-1:0]  left_q;
  logic [LANE_W-1:0]   lane_q;
  logic                pend_q;
  logic [DATA_W-1:0]   data_q;
  logic                res_acc_q;
  logic                res_rd_q;
  logic [COUNT_W-1:0]  res_short_q;
  logic [LEVEL_W-1:0]  res_fill_q;
  logic [LEVEL_W-1:0]  res_free_q;
  logic                out_valid_q;
  logic                accepted_q;
  logic [COUNT_W-1:0]  shortfall_q;
  logic [DATA_W-1:0]   read_data_q;
  logic [LEVEL_W-1:0]  fill_level_q;
  logic [LEVEL_W-1:0]  free_space_q;

  logic                cfg_fire;
  logic                in_fire;
  logic                out_free;
  logic [CNT_W-1:0]    lim_cap;
  logic [COUNT_W-1:0]  cnt;
  logic [CNT_W-1:0]    free_now;
  logic [CNT_W-1:0]    avail;
  logic                refuse;
  logic [CNT_W-1:0]    stored_d;
  logic [AW-1:0]       step_src;
  logic [CNT_W-1:0]    step_sum;
  logic [AW-1:0]       step_pos;
  logic                ram_en;
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [7:0]          ram_rdata;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE) | cfg_valid_i;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  always_comb begin
    if (cfg_capacity_i == '0) begin
      lim_cap = CNT_W'(1);
    end else if (32'(cfg_capacity_i) > 32'(RING_DEPTH)) begin
      lim_cap = CNT_W'(RING_DEPTH);
    end else begin
      lim_cap = CNT_W'(cfg_capacity_i);
    end
  end

  // occupancy check for the incoming request
  always_comb begin
    cnt      = (32'(byte_count_i) > 32'(BYTES_PER_REQUEST)) ?
               COUNT_W'(BYTES_PER_REQUEST) : byte_count_i;
    free_now = cap_q - stored_q;
    avail    = (req_type_i == REQ_READ) ? stored_q : free_now;
    refuse   = CNT_W'(cnt) > avail;
    stored_d = (req_type_i == REQ_READ) ? stored_q - CNT_W'(cnt) : stored_q + CNT_W'(cnt);
  end

  // position advance by one slot, wrapping at capacity
  always_comb begin
    step_src = (state_q == ST_WRITE) ? wr_pos_q : rd_pos_q;
    step_sum = CNT_W'(step_src) + CNT_W'(1);
    step_pos = (step_sum >= cap_q) ? '0 : AW'(step_sum);
  end

  assign ram_en   = (state_q == ST_WRITE) | (state_q == ST_READ);
  assign ram_we   = (state_q == ST_WRITE);
  assign ram_addr = (state_q == ST_WRITE) ? wr_pos_q : rd_pos_q;

  brb_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(data_q[7:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cap_q        <= CNT_W'(CapReset);
      stored_q     <= '0;
      wr_pos_q     <= '0;
      rd_pos_q     <= '0;
      left_q       <= '0;
      lane_q       <= '0;
      pend_q       <= 1'b0;
      data_q       <= '0;
      res_acc_q    <= 1'b0;
      res_rd_q     <= 1'b0;
      res_short_q  <= '0;
      res_fill_q   <= '0;
      res_free_q   <= '0;
      out_valid_q  <= 1'b0;
      accepted_q   <= 1'b0;
      shortfall_q  <= '0;
      read_data_q  <= '0;
      fill_level_q <= '0;
      free_space_q <= '0;
    end else begin
      pend_q <= (state_q == ST_READ);
      if (pend_q) begin
        data_q[8*lane_q +: 8] <= ram_rdata;
        lane_q                <= lane_q + LANE_W'(1);
      end
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (cfg_fire) begin
            cap_q    <= lim_cap;
            stored_q <= '0;
            wr_pos_q <= '0;
            rd_pos_q <= '0;
          end else if (in_fire) begin
            res_acc_q   <= ~refuse;
            res_rd_q    <= (req_type_i == REQ_READ) & ~refuse;
            res_short_q <= refuse ? COUNT_W'(CNT_W'(cnt) - avail) : '0;
            res_fill_q  <= LEVEL_W'(refuse ? stored_q : stored_d);
            res_free_q  <= LEVEL_W'(cap_q - (refuse ? stored_q : stored_d));
            if (!refuse) begin
              stored_q <= stored_d;
            end
            data_q <= (req_type_i == REQ_READ) ? '0 : write_data_i;
            left_q <= cnt;
            lane_q <= '0;
            if (refuse || cnt == '0) begin
              state_q <= ST_FINISH;
            end else if (req_type_i == REQ_READ) begin
              state_q <= ST_READ;
            end else begin
              state_q <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          data_q   <= data_q >> 8;
          wr_pos_q <= step_pos;
          left_q   <= left_q - COUNT_W'(1);
          if (left_q == COUNT_W'(1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_READ: begin
          rd_pos_q <= step_pos;
          left_q   <= left_q - COUNT_W'(1);
          if (left_q == COUNT_W'(1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            accepted_q   <= res_acc_q;
            shortfall_q  <= res_short_q;
            read_data_q  <= res_rd_q ? data_q : '0;
            fill_level_q <= res_fill_q;
            free_space_q <= res_free_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = accepted_q;
  assign shortfall_o  = shortfall_q;
  assign read_data_o  = read_data_q;
  assign fill_level_o = fill_level_q;
  assign free_space_o = free_space_q;

endmodule

// ----- rtl/core/brb_checker.sv -----
// port-level checks for the byte ring buffer, bound to the top level
// depends on brb_pkg and assert_macros.svh
`include "assert_macros.svh"

module brb_checker import brb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               accepted_o,
  input logic [COUNT_W-1:0] shortfall_o,
  input logic [DATA_W-1:0]  read_data_o,
  input logic [LEVEL_W-1:0] fill_level_o,
  input logic [LEVEL_W-1:0] free_space_o
);

  // stalled result holds
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
              out_valid_o && $stable(read_data_o))
  // stalled result status holds
  `ASSERT_NXT(a_out_meta, clk_i, rst_ni, out_valid_o && out_stall_i,
              $stable({accepted_o, shortfall_o, fill_level_o, free_space_o}))
  // refused request reports a shortfall and no data
  `ASSERT_IMP(a_refuse, clk_i, rst_ni, out_valid_o && !accepted_o, shortfall_o != '0 && read_data_o == '0)
  // done request has no shortfall
  `ASSERT_IMP(a_accept, clk_i, rst_ni, out_valid_o && accepted_o, shortfall_o == '0)
  // one request in flight at a time
  `ASSERT_NXT(a_single, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind byte_ring_buffer_transfers brb_checker u_brb_checker (.*);
